// ===== rtl/core/bhmap_pkg.sv =====
package bhmap_pkg;

   localparam int BUCKETS  = 1024;
   localparam int WAYS     = 4;
   localparam int KEY_W    = 20;
   localparam int VAL_W    = 31;
   localparam int BUCKET_W = $clog2(BUCKETS);
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

   typedef enum logic [1:0] {
      MODE_PUT    = 2'd0,
      MODE_GET    = 2'd1,
      MODE_REMOVE = 2'd2
   } mode_type;

   typedef struct packed {
      logic [1:0]       mode;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [VAL_W-1:0] read_value;
      logic             bucket_full;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } slot_type;

   typedef slot_type [WAYS-1:0] row_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic                clear_we;
      logic [BUCKET_W-1:0] clear_row;
      logic                capture;
      logic                execute;
   } ctrl_cmd_type;

endpackage

// ===== rtl/core/bhmap_ctrl.sv =====
module bhmap_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output bhmap_pkg::ctrl_cmd_type cmd
);
   import bhmap_pkg::*;

   state_type           state_ff, state_in;
   logic [BUCKET_W-1:0] clear_row_ff, clear_row_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_row_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clear_row_ff <= clear_row_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      clear_row_in  = clear_row_ff;
      busy          = 1'b1;
      cmd.clear_we  = 1'b0;
      cmd.clear_row = clear_row_ff;
      cmd.capture   = 1'b0;
      cmd.execute   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_we = 1'b1;
            clear_row_in = clear_row_ff + 1'b1;
            if (clear_row_ff == BUCKET_W'(BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/bhmap_datapath.sv =====
module bhmap_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  bhmap_pkg::ctrl_cmd_type cmd,
   input  bhmap_pkg::req_type     req_item,
   output logic                   rsp_valid,
   output bhmap_pkg::rsp_type     rsp_item
);
   import bhmap_pkg::*;

   row_type             mem [BUCKETS];
   row_type             rd_row_ff;
   req_type             req_ff;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff;

   logic                hit, has_free, row_we, exec_we;
   logic [WAY_W-1:0]    hit_way, free_way;
   row_type             new_row, wr_row;
   logic [BUCKET_W-1:0] wr_addr;

   // bucket count is a power of two: bucket is the key's low bits
   always_ff @(posedge clock) begin
      if (row_we) begin
         mem[wr_addr] <= wr_row;
      end
      if (cmd.capture) begin
         rd_row_ff <= mem[req_item.key[BUCKET_W-1:0]];
         req_ff    <= req_item;
      end
   end

   // lowest matching way and lowest free way
   always_comb begin
      hit      = 1'b0;
      hit_way  = '0;
      has_free = 1'b0;
      free_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (rd_row_ff[w].valid && rd_row_ff[w].key == req_ff.key) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (!rd_row_ff[w].valid) begin
            has_free = 1'b1;
            free_way = WAY_W'(w);
         end
      end
   end

   always_comb begin
      new_row = rd_row_ff;
      exec_we = 1'b0;
      rsp_in  = '0;
      case (req_ff.mode)
         MODE_PUT: begin
            if (hit) begin
               rsp_in.found           = 1'b1;
               new_row[hit_way].value = req_ff.value;
               exec_we                = 1'b1;
            end else if (has_free) begin
               new_row[free_way].valid = 1'b1;
               new_row[free_way].key   = req_ff.key;
               new_row[free_way].value = req_ff.value;
               exec_we                 = 1'b1;
            end else begin
               rsp_in.bucket_full = 1'b1;
            end
         end
         MODE_GET: begin
            if (hit) begin
               rsp_in.found      = 1'b1;
               rsp_in.read_value = rd_row_ff[hit_way].value;
            end
         end
         MODE_REMOVE: begin
            if (hit) begin
               rsp_in.found     = 1'b1;
               new_row[hit_way] = '0;
               exec_we          = 1'b1;
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   assign row_we  = cmd.clear_we | (cmd.execute & exec_we);
   assign wr_addr = cmd.clear_we ? cmd.clear_row : req_ff.key[BUCKET_W-1:0];
   assign wr_row  = cmd.clear_we ? row_type'('0) : new_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.execute;
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== rtl/core/bucketed_hash_map_top.sv =====
// the request is captured into the row and request registers, then the answer
// and its strobe are registered as the row is written back
// requests cannot overlap: busy holds off a new one during the read-modify-write of one
// bucket row in the slot memory (row read, then compare and write back)
// reset: synchronous; the slot memory is then swept one row a cycle, all 1024
// rows with busy high, before the first request is taken
// the result is shown for one cycle only; the receiver cannot stall
module bucketed_hash_map_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  bhmap_pkg::req_type req_item,
   output logic               rsp_valid,
   output bhmap_pkg::rsp_type rsp_item
);
   import bhmap_pkg::*;

   ctrl_cmd_type cmd;

   bhmap_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   bhmap_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== verif/tb_bucketed_hash_map_top.sv =====
module tb_bucketed_hash_map_top;
   import bhmap_pkg::*;

   localparam logic [1:0] MODE_NOP    = 2'd3;
   localparam int         NUM_RANDOM  = 650;
   localparam int         DRAIN_CYCLES = 8;

   class map_checker;
      bit               slot_used [BUCKETS][WAYS];
      bit [KEY_W-1:0]   slot_key  [BUCKETS][WAYS];
      bit [VAL_W-1:0]   slot_val  [BUCKETS][WAYS];
      rsp_type          pending_answers [$];
      int               errors;

      function int pending();
         return pending_answers.size();
      endfunction

      // apply one request to the table copy and queue the answer it should give
      function void note_request(req_type r);
         int      b;
         int      hit;
         int      free_way;
         rsp_type ans;
         b        = r.key % BUCKETS;
         hit      = -1;
         free_way = -1;
         ans      = '0;
         for (int w = 0; w < WAYS; w++) begin
            if (slot_used[b][w]) begin
               if (hit < 0 && slot_key[b][w] == r.key) hit = w;
            end else if (free_way < 0) begin
               free_way = w;
            end
         end
         case (r.mode)
            MODE_PUT: begin
               if (hit >= 0) begin
                  ans.found = 1'b1;
                  slot_val[b][hit] = r.value;
               end else if (free_way >= 0) begin
                  slot_used[b][free_way] = 1'b1;
                  slot_key[b][free_way]  = r.key;
                  slot_val[b][free_way]  = r.value;
               end else begin
                  ans.bucket_full = 1'b1;
               end
            end
            MODE_GET: begin
               if (hit >= 0) begin
                  ans.found      = 1'b1;
                  ans.read_value = slot_val[b][hit];
               end
            end
            MODE_REMOVE: begin
               if (hit >= 0) begin
                  ans.found = 1'b1;
                  slot_used[b][hit] = 1'b0;
                  slot_key[b][hit]  = '0;
                  slot_val[b][hit]  = '0;
               end
            end
            default: ;
         endcase
         pending_answers.push_back(ans);
      endfunction

      function void check_answer(rsp_type got);
         rsp_type want;
         if (pending_answers.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, got %h", $time, got);
            return;
         end
         want = pending_answers.pop_front();
         if (got.found !== want.found) begin
            errors++;
            $display("%0t: found expected %0d, got %0d", $time, want.found, got.found);
         end
         if (got.read_value !== want.read_value) begin
            errors++;
            $display("%0t: read_value expected %h, got %h", $time, want.read_value,
                     got.read_value);
         end
         if (got.bucket_full !== want.bucket_full) begin
            errors++;
            $display("%0t: bucket_full expected %0d, got %0d", $time, want.bucket_full,
                     got.bucket_full);
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;

   map_checker sb = new();

   always #4 clock = ~clock;

   bucketed_hash_map_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_request(req_item);
         if (rsp_valid) sb.check_answer(rsp_item);
      end
   end

   function automatic req_type make_req(logic [1:0] mode, logic [KEY_W-1:0] key,
                                        logic [VAL_W-1:0] value);
      req_type r;
      r.mode  = mode;
      r.key   = key;
      r.value = value;
      return r;
   endfunction

   // mostly a few crowded buckets so that collisions and full buckets happen
   function automatic logic [KEY_W-1:0] random_key();
      int unsigned b;
      int unsigned tag;
      if ($urandom_range(0, 9) == 0) return KEY_W'($urandom);
      b   = ($urandom_range(0, 3) == 3) ? BUCKETS - 1 : $urandom_range(0, 2);
      tag = ($urandom_range(0, 19) == 0) ? (1 << (KEY_W - BUCKET_W)) - 1
                                         : $urandom_range(0, 5);
      return KEY_W'(tag * BUCKETS + b);
   endfunction

   function automatic logic [VAL_W-1:0] random_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   function automatic req_type random_req();
      int unsigned pick;
      logic [1:0]  mode;
      pick = $urandom_range(0, 99);
      if (pick < 45)      mode = MODE_PUT;
      else if (pick < 75) mode = MODE_GET;
      else if (pick < 95) mode = MODE_REMOVE;
      else                mode = MODE_NOP;
      return make_req(mode, random_key(), random_value());
   endfunction

   task automatic send_request(input req_type r);
      start    <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic hold_off(input int cycles);
      start    <= 1'b0;
      req_item <= random_req();
      repeat (cycles) @(posedge clock);
   endtask

   initial begin
      req_type directed [$];
      int      idle_pct;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      directed.push_back(make_req(MODE_PUT,    20'h00000, '0));
      directed.push_back(make_req(MODE_PUT,    20'hFFFFF, '1));
      directed.push_back(make_req(MODE_GET,    20'h00000, '1));
      directed.push_back(make_req(MODE_GET,    20'hFFFFF, '0));
      directed.push_back(make_req(MODE_GET,    20'h00001, '0));
      directed.push_back(make_req(MODE_REMOVE, 20'h12345, '0));
      // fill one bucket, then overflow it
      for (int i = 0; i < WAYS; i++)
         directed.push_back(make_req(MODE_PUT, KEY_W'(i * BUCKETS + 5),
                                     VAL_W'(31'h1000 + i)));
      directed.push_back(make_req(MODE_PUT,    KEY_W'(WAYS * BUCKETS + 5), 31'h2AAA_AAAA));
      directed.push_back(make_req(MODE_PUT,    KEY_W'(2 * BUCKETS + 5), 31'h5555_5555));
      directed.push_back(make_req(MODE_GET,    KEY_W'(2 * BUCKETS + 5), '0));
      directed.push_back(make_req(MODE_REMOVE, KEY_W'(BUCKETS + 5), '0));
      directed.push_back(make_req(MODE_PUT,    KEY_W'(WAYS * BUCKETS + 5), 31'h0123_4567));
      directed.push_back(make_req(MODE_GET,    KEY_W'(WAYS * BUCKETS + 5), '0));
      directed.push_back(make_req(MODE_GET,    KEY_W'(BUCKETS + 5), '0));
      directed.push_back(make_req(MODE_NOP,    20'hFFFFF, '1));
      directed.push_back(make_req(MODE_GET,    20'hFFFFF, '0));
      directed.push_back(make_req(MODE_REMOVE, 20'hFFFFF, '0));
      directed.push_back(make_req(MODE_GET,    20'hFFFFF, '0));
      directed.push_back(make_req(MODE_PUT,    20'h00000, 31'h5555_5555));
      foreach (directed[i]) send_request(directed[i]);

      // let the pipe run dry before the random part
      hold_off(1);
      while (sb.pending() != 0) @(posedge clock);

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 25 : (phase == 1) ? 61 : 0;
         for (int n = 0; n < NUM_RANDOM / 3; n++) begin
            if ($urandom_range(0, 99) < idle_pct) hold_off($urandom_range(1, 4));
            send_request(random_req());
         end
      end

      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("tb_bucketed_hash_map_top passed");
      else
         $display("tb_bucketed_hash_map_top failed");
      $finish;
   end

   initial begin
      #(8 * 200000);
      $display("tb_bucketed_hash_map_top failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/bhmap_pkg.sv
rtl/core/bhmap_ctrl.sv
rtl/core/bhmap_datapath.sv
rtl/core/bucketed_hash_map_top.sv
verif/tb_bucketed_hash_map_top.sv
